[src/led_grid_frame_packer_assert.svh]
// Assertion macros for the LED grid frame packer.
// Used by lgfp_walker and lgfp_packer; expects clk_i and rst_ni in scope.
`ifndef LED_GRID_FRAME_PACKER_ASSERT_SVH
`define LED_GRID_FRAME_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define LGFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lgfp: assertion failed");
`define LGFP_ASSERT_NEVER(lbl, expr) `LGFP_ASSERT(lbl, !(expr))
`else
`define LGFP_ASSERT(lbl, prop)
`define LGFP_ASSERT_NEVER(lbl, expr)
`endif
`endif

[src/lgfp_pkg.sv]
// Shared types and constants of the LED grid frame packer.
// No dependencies.
package lgfp_pkg;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_SHOW = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] MODE_ONOFF  = 2'd0;
  localparam logic [1:0] MODE_SERIES = 2'd1;
  localparam logic [1:0] MODE_GRIDS  = 2'd2;
  localparam logic [1:0] MODE_QUIET  = 2'd3;

  localparam logic [7:0] CFG_MODE = 8'd0;
  localparam logic [7:0] CFG_VARI = 8'd1;
  localparam logic [7:0] CFG_COLS = 8'd2;
  localparam logic [7:0] CFG_ROWS = 8'd3;

  localparam logic [7:0] MSG_LED_ON  = 8'h21;
  localparam logic [7:0] MSG_LED_OFF = 8'h20;
  localparam logic [7:0] MSG_COL     = 8'h80;
  localparam logic [7:0] MSG_MAP     = 8'h14;
  localparam logic [7:0] MSG_LEVEL   = 8'h1A;
  localparam logic [7:0] QUAD_OFS    = 8'h08;
  localparam logic [7:0] NIB_MASK    = 8'h0F;

  typedef enum logic [2:0] {
    W_CLEAR, W_IDLE, W_SET_HDR, W_F0_HDR, W_F0_CELL, W_Q_HDR, W_Q_CELL, W_READ
  } walk_state_e;

  typedef enum logic [1:0] {
    STEP_HDR, STEP_CELL, STEP_READ
  } step_kind_e;

  typedef struct packed {
    logic       valid;
    step_kind_e kind;
    logic [7:0] hdr_byte;
    logic       incl;
    logic       nib;
    logic [2:0] shift;
    logic       byte_done;
    logic       msg_done;
    logic       item_last;
  } step_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] page;
    logic [3:0] column;
    logic [3:0] row;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [63:0] frame_bytes;
    logic [3:0]  byte_count;
    logic        end_of_message;
    logic [7:0]  read_value;
    logic        last;
  } out_t;

endpackage

[src/lgfp_cell_mem.sv]
// Single-port cell store with a registered read.
// No dependencies.
module lgfp_cell_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/lgfp_walker.sv]
// Sequencer: clears the store, decodes items, walks cells and issues steps.
// Depends on lgfp_pkg and led_grid_frame_packer_assert.svh.
`include "led_grid_frame_packer_assert.svh"
module lgfp_walker #(
  parameter int PAGES    = 4,
  parameter int MAX_SIDE = 16,
  parameter int DEPTH    = 1024,
  parameter int AW       = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lgfp_pkg::in_t  in_data_i,
  input  logic [1:0]     mode_i,
  input  logic           vari_i,
  input  logic [4:0]     cc_i,
  input  logic [4:0]     rc_i,
  input  logic           adv_i,
  output lgfp_pkg::step_t step_o,
  output logic           mem_we_o,
  output logic           mem_re_o,
  output logic [AW-1:0]  mem_addr_o,
  output logic [7:0]     mem_wdata_o
);

  lgfp_pkg::walk_state_e state_q, state_d;
  logic [1:0]    shown_q, shown_d, q_q, q_d, hidx_q, hidx_d;
  logic [3:0]    oi_q, oi_d, ii_q, ii_d;
  logic [3:0]    set_col_q, set_col_d, set_row_q, set_row_d;
  logic          set_on_q, set_on_d, rd_ok_q, rd_ok_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d, clr_q, clr_d;

  function automatic logic [AW-1:0] cell_addr(logic [1:0] p, logic [3:0] c, logic [3:0] r);
    return AW'((int'(p) * MAX_SIDE + int'(c)) * MAX_SIDE + int'(r));
  endfunction

  logic       in_ok, page_ok, vari_eff, hdr_last, q_final, q_msg_done, q_byte_done;
  logic       f0_row_done, f0_col_done, q_incl;
  logic [4:0] f0_bit, qc, qr;
  lgfp_pkg::walk_state_e frame_state;

  always_comb begin
    page_ok     = int'(in_data_i.page) < PAGES;
    in_ok       = page_ok && int'(in_data_i.column) < MAX_SIDE
                  && int'(in_data_i.row) < MAX_SIDE;
    vari_eff    = (mode_i == lgfp_pkg::MODE_GRIDS) && vari_i;
    hdr_last    = (mode_i == lgfp_pkg::MODE_SERIES) ? (hidx_q == 2'd0) : (hidx_q == 2'd2);
    qc          = {1'b0, q_q[0], ii_q[2:0]};
    qr          = {1'b0, q_q[1], oi_q[2:0]};
    q_incl      = (qc < cc_i) && (qr < rc_i);
    q_msg_done  = (oi_q[2:0] == 3'd7) && (ii_q[2:0] == 3'd7);
    q_byte_done = vari_eff ? ii_q[0] : (ii_q[2:0] == 3'd7);
    q_final     = (q_q == 2'd3) || (vari_eff && (((q_q == 2'd0) && (cc_i <= 5'd8))
                  || ((q_q == 2'd1) && (rc_i <= 5'd8))));
    f0_bit      = rc_i - 5'd1 - {1'b0, ii_q};
    f0_row_done = ({1'b0, ii_q} == rc_i - 5'd1);
    f0_col_done = ({1'b0, oi_q} == cc_i - 5'd1);
    frame_state = (mode_i == lgfp_pkg::MODE_ONOFF) ? lgfp_pkg::W_F0_HDR : lgfp_pkg::W_Q_HDR;
  end

  // next state
  always_comb begin
    state_d   = state_q;
    shown_d   = shown_q;
    q_d       = q_q;
    hidx_d    = hidx_q;
    oi_d      = oi_q;
    ii_d      = ii_q;
    set_col_d = set_col_q;
    set_row_d = set_row_q;
    set_on_d  = set_on_q;
    rd_ok_d   = rd_ok_q;
    rd_addr_d = rd_addr_q;
    clr_d     = clr_q;
    unique case (state_q)
      lgfp_pkg::W_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) state_d = lgfp_pkg::W_IDLE;
      end
      lgfp_pkg::W_IDLE: begin
        q_d    = 2'd0;
        hidx_d = 2'd0;
        oi_d   = 4'd0;
        ii_d   = 4'd0;
        if (in_valid_i) begin
          case (in_data_i.op)
            lgfp_pkg::OP_SET: begin
              set_col_d = in_data_i.column;
              set_row_d = in_data_i.row;
              set_on_d  = in_data_i.value != 8'd0;
              if (in_ok && in_data_i.page == shown_q && mode_i != lgfp_pkg::MODE_QUIET) begin
                state_d = (mode_i == lgfp_pkg::MODE_ONOFF) ? lgfp_pkg::W_SET_HDR : frame_state;
              end
            end
            lgfp_pkg::OP_SHOW: begin
              if (page_ok) begin
                shown_d = in_data_i.page;
                if (mode_i != lgfp_pkg::MODE_QUIET) state_d = frame_state;
              end
            end
            lgfp_pkg::OP_READ: begin
              rd_ok_d   = in_ok;
              rd_addr_d = cell_addr(in_data_i.page, in_data_i.column, in_data_i.row);
              state_d   = lgfp_pkg::W_READ;
            end
            default: ;
          endcase
        end
      end
      lgfp_pkg::W_SET_HDR: begin
        if (adv_i) begin
          hidx_d = hidx_q + 2'd1;
          if (hidx_q == 2'd1) state_d = lgfp_pkg::W_IDLE;
        end
      end
      lgfp_pkg::W_F0_HDR: begin
        if (adv_i) begin
          ii_d    = 4'd0;
          state_d = lgfp_pkg::W_F0_CELL;
        end
      end
      lgfp_pkg::W_F0_CELL: begin
        if (adv_i) begin
          ii_d = ii_q + 4'd1;
          if (f0_row_done) begin
            oi_d    = oi_q + 4'd1;
            state_d = f0_col_done ? lgfp_pkg::W_IDLE : lgfp_pkg::W_F0_HDR;
          end
        end
      end
      lgfp_pkg::W_Q_HDR: begin
        if (adv_i) begin
          hidx_d = hidx_q + 2'd1;
          if (hdr_last) begin
            oi_d    = 4'd0;
            ii_d    = 4'd0;
            state_d = lgfp_pkg::W_Q_CELL;
          end
        end
      end
      lgfp_pkg::W_Q_CELL: begin
        if (adv_i) begin
          ii_d = {1'b0, ii_q[2:0] + 3'd1};
          if (ii_q[2:0] == 3'd7) oi_d = oi_q + 4'd1;
          if (q_msg_done) begin
            q_d     = q_q + 2'd1;
            hidx_d  = 2'd0;
            state_d = q_final ? lgfp_pkg::W_IDLE : lgfp_pkg::W_Q_HDR;
          end
        end
      end
      lgfp_pkg::W_READ: begin
        if (adv_i) state_d = lgfp_pkg::W_IDLE;
      end
      default: state_d = lgfp_pkg::W_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    step_o      = '0;
    step_o.kind = lgfp_pkg::STEP_HDR;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = '0;
    mem_wdata_o = 8'd0;
    in_stall_o  = state_q != lgfp_pkg::W_IDLE;
    unique case (state_q)
      lgfp_pkg::W_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
      end
      lgfp_pkg::W_IDLE: begin
        if (in_valid_i && in_data_i.op == lgfp_pkg::OP_SET && in_ok) begin
          mem_we_o    = 1'b1;
          mem_addr_o  = cell_addr(in_data_i.page, in_data_i.column, in_data_i.row);
          mem_wdata_o = in_data_i.value;
        end
      end
      lgfp_pkg::W_SET_HDR: begin
        step_o.valid = 1'b1;
        if (hidx_q == 2'd0) begin
          step_o.hdr_byte = set_on_q ? lgfp_pkg::MSG_LED_ON : lgfp_pkg::MSG_LED_OFF;
        end else begin
          step_o.hdr_byte  = {set_col_q, set_row_q};
          step_o.msg_done  = 1'b1;
          step_o.item_last = 1'b1;
        end
      end
      lgfp_pkg::W_F0_HDR: begin
        step_o.valid    = 1'b1;
        step_o.hdr_byte = lgfp_pkg::MSG_COL | {4'd0, oi_q};
      end
      lgfp_pkg::W_F0_CELL: begin
        step_o.valid     = 1'b1;
        step_o.kind      = lgfp_pkg::STEP_CELL;
        step_o.incl      = f0_bit[4:3] == 2'd0;
        step_o.shift     = f0_bit[2:0];
        step_o.byte_done = f0_row_done;
        step_o.msg_done  = f0_row_done && f0_col_done;
        step_o.item_last = f0_row_done && f0_col_done;
        mem_re_o         = adv_i && step_o.incl;
        mem_addr_o       = cell_addr(shown_q, oi_q, ii_q);
      end
      lgfp_pkg::W_Q_HDR: begin
        step_o.valid = 1'b1;
        if (mode_i == lgfp_pkg::MODE_SERIES) begin
          step_o.hdr_byte = lgfp_pkg::MSG_COL | {6'd0, q_q};
        end else if (hidx_q == 2'd0) begin
          step_o.hdr_byte = vari_eff ? lgfp_pkg::MSG_LEVEL : lgfp_pkg::MSG_MAP;
        end else if (hidx_q == 2'd1) begin
          step_o.hdr_byte = q_q[0] ? lgfp_pkg::QUAD_OFS : 8'd0;
        end else begin
          step_o.hdr_byte = q_q[1] ? lgfp_pkg::QUAD_OFS : 8'd0;
        end
      end
      lgfp_pkg::W_Q_CELL: begin
        step_o.valid     = 1'b1;
        step_o.kind      = lgfp_pkg::STEP_CELL;
        step_o.incl      = q_incl;
        step_o.nib       = vari_eff;
        step_o.shift     = vari_eff ? (ii_q[0] ? 3'd0 : 3'd4) : ii_q[2:0];
        step_o.byte_done = q_byte_done;
        step_o.msg_done  = q_msg_done;
        step_o.item_last = q_msg_done && q_final;
        mem_re_o         = adv_i && q_incl;
        mem_addr_o       = cell_addr(shown_q, qc[3:0], qr[3:0]);
      end
      lgfp_pkg::W_READ: begin
        step_o.valid     = 1'b1;
        step_o.kind      = lgfp_pkg::STEP_READ;
        step_o.incl      = rd_ok_q;
        step_o.item_last = 1'b1;
        mem_re_o         = adv_i && rd_ok_q;
        mem_addr_o       = rd_addr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgfp_pkg::W_CLEAR;
      shown_q <= 2'd0;
      q_q     <= 2'd0;
      hidx_q  <= 2'd0;
      oi_q    <= 4'd0;
      ii_q    <= 4'd0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      shown_q <= shown_d;
      q_q     <= q_d;
      hidx_q  <= hidx_d;
      oi_q    <= oi_d;
      ii_q    <= ii_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_col_q <= set_col_d;
    set_row_q <= set_row_d;
    set_on_q  <= set_on_d;
    rd_ok_q   <= rd_ok_d;
    rd_addr_q <= rd_addr_d;
  end

  `LGFP_ASSERT_NEVER(a_port_conflict, mem_we_o && mem_re_o)
  `LGFP_ASSERT(a_clear_writes, state_q == lgfp_pkg::W_CLEAR |-> mem_we_o && !mem_re_o)
  `LGFP_ASSERT(a_read_in_range, mem_re_o |-> int'(mem_addr_o) < DEPTH)

endmodule

[src/lgfp_packer.sv]
// Step consumer: folds cell reads into bytes, bytes into 8-byte words, and passes read values out.
// Depends on lgfp_pkg and led_grid_frame_packer_assert.svh.
`include "led_grid_frame_packer_assert.svh"
module lgfp_packer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lgfp_pkg::step_t step_i,
  input  logic [7:0]      rdata_i,
  output logic            adv_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lgfp_pkg::out_t  out_data_o
);

  lgfp_pkg::step_t step_q;
  logic [7:0]  acc_q, acc_d, contrib, nbyte;
  logic [63:0] word_q, word_d, word_new;
  logic [2:0]  wcnt_q, wcnt_d;
  logic        out_valid_q, out_valid_d, append, push;
  lgfp_pkg::out_t out_q, out_d;

  assign adv_o = !out_valid_q || !out_stall_i;

  always_comb begin
    if (!step_q.incl) begin
      contrib = 8'd0;
    end else if (step_q.nib) begin
      contrib = (rdata_i & lgfp_pkg::NIB_MASK) << step_q.shift;
    end else begin
      contrib = (rdata_i != 8'd0) ? (8'd1 << step_q.shift) : 8'd0;
    end
    nbyte  = (step_q.kind == lgfp_pkg::STEP_HDR) ? step_q.hdr_byte : (acc_q | contrib);
    append = step_q.kind == lgfp_pkg::STEP_HDR
             || (step_q.kind == lgfp_pkg::STEP_CELL && step_q.byte_done);
    push   = (append && (wcnt_q == 3'd7 || step_q.msg_done))
             || step_q.kind == lgfp_pkg::STEP_READ;
    for (int k = 0; k < 8; k++) begin
      word_new[k*8 +: 8] = (wcnt_q == 3'(k)) ? nbyte : word_q[k*8 +: 8];
    end
    acc_d       = acc_q;
    word_d      = word_q;
    wcnt_d      = wcnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (adv_o && step_q.valid) begin
      if (step_q.kind == lgfp_pkg::STEP_CELL) acc_d = append ? 8'd0 : nbyte;
      if (push) begin
        word_d      = 64'd0;
        wcnt_d      = 3'd0;
        out_valid_d = 1'b1;
        if (step_q.kind == lgfp_pkg::STEP_READ) begin
          out_d            = '0;
          out_d.read_value = step_q.incl ? rdata_i : 8'd0;
          out_d.last       = 1'b1;
        end else begin
          out_d.frame_bytes    = word_new;
          out_d.byte_count     = {1'b0, wcnt_q} + 4'd1;
          out_d.end_of_message = step_q.msg_done;
          out_d.read_value     = 8'd0;
          out_d.last           = step_q.item_last && step_q.msg_done;
        end
      end else if (append) begin
        word_d = word_new;
        wcnt_d = wcnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      acc_q       <= 8'd0;
      word_q      <= 64'd0;
      wcnt_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) step_q <= step_i;
      acc_q       <= acc_d;
      word_q      <= word_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LGFP_ASSERT_NEVER(a_read_mid_word,
    step_q.valid && step_q.kind == lgfp_pkg::STEP_READ && wcnt_q != 3'd0)
  `LGFP_ASSERT(a_acc_clear_on_hdr,
    step_q.valid && step_q.kind == lgfp_pkg::STEP_HDR |-> acc_q == 8'd0)
  `LGFP_ASSERT(a_hold_on_stall,
    out_valid_q && out_stall_i |=> $stable(step_q) && $stable(wcnt_q))

endmodule

[src/led_grid_frame_packer.sv]
// LED grid frame packer top level: configuration registers and module wiring.
// Depends on lgfp_pkg, lgfp_cell_mem, lgfp_walker, lgfp_packer.
//
// After reset the block clears all PAGES*MAX_SIDE*MAX_SIDE entries of its cell
// store (1024 at defaults), one entry per cycle, and holds in_stall_o high
// until done. Every item is then handled alone through the single port of the
// cell store, one cell read per cycle unless the result side stalls: a read
// is one step, an on/off set message two header bytes, a mode 0 frame a
// column header and a cell step per row for each column, a quadrant frame its
// header bytes and 64 cells per quadrant. Configuration writes are always taken.
module led_grid_frame_packer #(
  parameter int PAGES    = 4,
  parameter int MAX_SIDE = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lgfp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lgfp_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);

  localparam int DEPTH = PAGES * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [1:0] mode_q;
  logic       vari_q;
  logic [4:0] cols_q, rows_q, cc, rc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lgfp_pkg::MODE_GRIDS;
      vari_q <= 1'b0;
      cols_q <= 5'd8;
      rows_q <= 5'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lgfp_pkg::CFG_MODE: mode_q <= cfg_data_i[1:0];
        lgfp_pkg::CFG_VARI: vari_q <= cfg_data_i[0];
        lgfp_pkg::CFG_COLS: cols_q <= cfg_data_i[4:0];
        lgfp_pkg::CFG_ROWS: rows_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cc = (cols_q == 5'd0) ? 5'd1 : ((int'(cols_q) > MAX_SIDE) ? 5'(MAX_SIDE) : cols_q);
    rc = (rows_q == 5'd0) ? 5'd1 : ((int'(rows_q) > MAX_SIDE) ? 5'(MAX_SIDE) : rows_q);
  end

  lgfp_pkg::step_t step;
  logic          adv, mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  lgfp_cell_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  lgfp_walker #(.PAGES(PAGES), .MAX_SIDE(MAX_SIDE), .DEPTH(DEPTH), .AW(AW)) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .mode_i      (mode_q),
    .vari_i      (vari_q),
    .cc_i        (cc),
    .rc_i        (rc),
    .adv_i       (adv),
    .step_o      (step),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  lgfp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rdata_i     (mem_rdata),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
